// ----- hdl/dcl_pkg.sv -----
// shared types, phase codes, command codes and pattern characters
// for the drive command line parser; no dependencies
package dcl_pkg;

  localparam logic [4:0] PH_LIT0  = 5'd0;
  localparam logic [4:0] PH_LIT5  = 5'd5;
  localparam logic [4:0] PH_XPRE  = 5'd6;
  localparam logic [4:0] PH_XBODY = 5'd7;
  localparam logic [4:0] PH_LIT1  = 5'd8;
  localparam logic [4:0] PH_LIT3  = 5'd10;
  localparam logic [4:0] PH_YPRE  = 5'd11;
  localparam logic [4:0] PH_YBODY = 5'd12;
  localparam logic [4:0] PH_SEMI  = 5'd13;
  localparam logic [4:0] PH_DONE  = 5'd14;

  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_FWD   = 3'd2;
  localparam logic [2:0] CMD_BACK  = 3'd3;
  localparam logic [2:0] CMD_LEFT  = 3'd4;
  localparam logic [2:0] CMD_RIGHT = 3'd5;

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_VT    = 8'd11;
  localparam logic [7:0] CH_FF    = 8'd12;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [15:0] MAG_CAP = 16'd32768;
  localparam logic [15:0] POS_MAX = 16'd32767;
  localparam logic [14:0] DEADBAND_RST = 15'd15;

  typedef struct packed {
    logic [4:0]         phase;
    logic [15:0]        acc;
    logic               neg;
    logic               seen;
    logic signed [15:0] px;
    logic signed [15:0] py;
  } line_state_t;

  localparam line_state_t LINE_CLEAR = '{
    phase: PH_LIT0, acc: 16'd0, neg: 1'b0, seen: 1'b0, px: 16'sd0, py: 16'sd0
  };

  function automatic logic [7:0] head_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h52;
      3'd2:    ch = 8'h50;
      3'd3:    ch = CH_COMMA;
      3'd4:    ch = 8'h58;
      default: ch = CH_COMMA;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] mid_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd1:    ch = 8'h59;
      default: ch = CH_COMMA;
    endcase
    return ch;
  endfunction

endpackage

// ----- hdl/dcl_rx_if.sv -----
// received byte channel: valid, ready and one character per beat
// no dependencies
interface dcl_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- hdl/dcl_cmd_if.sv -----
// drive decision channel: valid, ready and one decision per beat
// no dependencies
interface dcl_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         drive_command;
  logic [15:0]        speed_hundredths;
  logic signed [15:0] x_value;
  logic signed [15:0] y_value;

  modport source (output valid, output drive_command, output speed_hundredths,
                  output x_value, output y_value, input ready);
  modport sink (input valid, input drive_command, input speed_hundredths,
                input x_value, input y_value, output ready);
endinterface

// ----- hdl/dcl_cfg_if.sv -----
// deadband write channel: valid, ready and the register value
// no dependencies
interface dcl_cfg_if;
  logic        valid;
  logic        ready;
  logic [14:0] deadband;

  modport source (output valid, output deadband, input ready);
  modport sink (input valid, input deadband, output ready);
endinterface

// ----- hdl/dcl_match.sv -----
// per-byte pattern matcher: next line state from current state and one byte
// depends on dcl_pkg
module dcl_match (
  input  dcl_pkg::line_state_t cur,
  input  logic [7:0]           rx_byte,
  output dcl_pkg::line_state_t nxt
);
  import dcl_pkg::*;

  logic        is_digit;
  logic        is_blank;
  logic        is_sign;
  logic [3:0]  dval;
  logic [19:0] acc_ext;
  logic [15:0] acc_step;
  logic signed [15:0] num_val;

  assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) || (rx_byte == CH_VT) ||
                    (rx_byte == CH_FF) || (rx_byte == CH_CR);
  assign is_sign  = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
  assign dval     = 4'(rx_byte - CH_ZERO);

  assign acc_ext  = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + {16'd0, dval};
  assign acc_step = (acc_ext > {4'd0, MAG_CAP}) ? MAG_CAP : acc_ext[15:0];

  always_comb begin
    if (cur.neg) begin
      num_val = 16'(-$signed({1'b0, cur.acc}));
    end else begin
      num_val = (cur.acc > POS_MAX) ? POS_MAX : cur.acc;
    end
  end

  always_comb begin
    nxt = cur;
    if ((rx_byte == CH_NUL) || (rx_byte == CH_NL)) begin
      if (cur.seen && (cur.phase == PH_XBODY)) nxt.px = num_val;
      if (cur.seen && (cur.phase == PH_YBODY)) nxt.py = num_val;
      nxt.phase = PH_DONE;
    end else begin
      unique case (cur.phase) inside
        [PH_LIT0:PH_LIT5]: begin
          nxt.phase = (rx_byte == head_char(cur.phase[2:0])) ? cur.phase + 5'd1 : PH_DONE;
        end
        PH_XPRE, PH_YPRE: begin
          if (!is_blank) begin
            nxt.acc   = 16'd0;
            nxt.neg   = 1'b0;
            nxt.seen  = 1'b0;
            nxt.phase = cur.phase + 5'd1;
            if (is_sign) begin
              nxt.neg = (rx_byte == CH_MINUS);
            end else if (is_digit) begin
              nxt.acc  = {12'd0, dval};
              nxt.seen = 1'b1;
            end else begin
              nxt.phase = PH_DONE;
            end
          end
        end
        PH_XBODY, PH_YBODY: begin
          if (is_digit) begin
            nxt.acc  = acc_step;
            nxt.seen = 1'b1;
          end else if (!cur.seen) begin
            nxt.phase = PH_DONE;
          end else if (cur.phase == PH_XBODY) begin
            nxt.px    = num_val;
            nxt.phase = (rx_byte == CH_COMMA) ? PH_LIT1 + 5'd1 : PH_DONE;
          end else begin
            nxt.py    = num_val;
            nxt.phase = PH_DONE;
          end
        end
        [PH_LIT1:PH_LIT3]: begin
          nxt.phase = (rx_byte == mid_char(2'(cur.phase - PH_LIT1))) ?
                      cur.phase + 5'd1 : PH_DONE;
        end
        default: begin
          nxt.phase = PH_DONE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/drive_command_line_parser_core.sv -----
// Drive command line parser. Takes one received byte per clock and matches
// each line against "$RP,X,<int>,Y,<int>"; what follows the y value is not
// checked. Every newline yields one drive decision with the parsed x and y
// values and a speed in hundredths. A byte is accepted every cycle while
// results are taken; a newline's byte is first loaded into the byte register,
// and its decision into the result register when the newline moves on. A
// waiting result holds a following newline in the byte register, and the bytes
// behind it wait too; bytes ahead of that newline keep flowing. The deadband
// register takes a write in any cycle, resets to 15 and must be changed only
// while idle.
// depends on dcl_pkg, dcl_match, dcl_rx_if, dcl_cmd_if, dcl_cfg_if
module drive_command_line_parser_core (
  input  logic    clk,
  input  logic    rst_n,
  dcl_rx_if.sink  in_bus,
  dcl_cmd_if.source out_bus,
  dcl_cfg_if.sink cfg_bus
);
  import dcl_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic [14:0] deadband_r;
  line_state_t st_r;
  line_state_t st_nxt;

  logic               out_valid_r;
  logic [2:0]         out_cmd_r;
  logic [15:0]        out_speed_r;
  logic signed [15:0] out_x_r;
  logic signed [15:0] out_y_r;

  logic               s1_is_nl;
  logic               out_free;
  logic               s1_go;
  logic [2:0]         cmd_nxt;
  logic [15:0]        speed_nxt;
  logic signed [16:0] x_w;
  logic signed [16:0] y_w;
  logic signed [16:0] db_w;
  logic               x_centred;
  logic               y_centred;

  dcl_match u_match (
    .cur     (st_r),
    .rx_byte (s1_byte_r),
    .nxt     (st_nxt)
  );

  assign s1_is_nl      = (s1_byte_r == CH_NL);
  assign out_free      = !out_valid_r || out_bus.ready;
  assign s1_go         = s1_valid_r && (!s1_is_nl || out_free);
  assign in_bus.ready  = !s1_valid_r || s1_go;
  assign cfg_bus.ready = 1'b1;

  assign out_bus.valid            = out_valid_r;
  assign out_bus.drive_command    = out_cmd_r;
  assign out_bus.speed_hundredths = out_speed_r;
  assign out_bus.x_value          = out_x_r;
  assign out_bus.y_value          = out_y_r;

  // decision on the values finished by the newline
  assign x_w       = 17'(st_nxt.px);
  assign y_w       = 17'(st_nxt.py);
  assign db_w      = $signed({2'b00, deadband_r});
  assign x_centred = (x_w > -db_w) && (x_w < db_w);
  assign y_centred = (y_w > -db_w) && (y_w < db_w);

  always_comb begin
    cmd_nxt   = CMD_NONE;
    speed_nxt = 16'd0;
    if ((x_w == 17'sd0) && (y_w == 17'sd0)) begin
      cmd_nxt = CMD_STOP;
    end else if (x_centred) begin
      if (y_w > 17'sd0) begin
        cmd_nxt   = CMD_FWD;
        speed_nxt = y_w[15:0];
      end else if (y_w < 17'sd0) begin
        cmd_nxt   = CMD_BACK;
        speed_nxt = 16'(-y_w);
      end
    end else if (y_centred) begin
      if (x_w < 17'sd0) begin
        cmd_nxt   = CMD_LEFT;
        speed_nxt = 16'(-x_w);
      end else if (x_w > 17'sd0) begin
        cmd_nxt   = CMD_RIGHT;
        speed_nxt = x_w[15:0];
      end
    end else begin
      cmd_nxt = CMD_STOP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      deadband_r  <= DEADBAND_RST;
      st_r        <= LINE_CLEAR;
    end else begin
      if (cfg_bus.valid) deadband_r <= cfg_bus.deadband;
      if (in_bus.ready) s1_valid_r <= in_bus.valid;
      if (s1_go) st_r <= s1_is_nl ? LINE_CLEAR : st_nxt;
      if (s1_go && s1_is_nl) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) s1_byte_r <= in_bus.rx_byte;
    if (s1_go && s1_is_nl) begin
      out_cmd_r   <= cmd_nxt;
      out_speed_r <= speed_nxt;
      out_x_r     <= st_nxt.px;
      out_y_r     <= st_nxt.py;
    end
  end

  a_result_from_newline: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_is_nl))
    else $error("result raised without a newline beat");

  a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_is_nl) |=> (st_r.phase == PH_LIT0) && (st_r.px == 16'sd0) &&
                            (st_r.py == 16'sd0) && !st_r.seen)
    else $error("line state not cleared after newline");

  a_speed_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((out_cmd_r == CMD_NONE) || (out_cmd_r == CMD_STOP))) |->
    (out_speed_r == 16'd0))
    else $error("speed non-zero for stop or no change");

  a_newline_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_is_nl && !out_free) |=> (s1_valid_r && s1_is_nl))
    else $error("newline beat dropped while result stalled");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// testbench for drive_command_line_parser_core: byte streams in, drive decisions checked
// against a line parser mirror kept here; depends on dcl_pkg and the three channel interfaces
module tb;
  import dcl_pkg::*;

  typedef struct {
    logic [2:0]  cmd;
    logic [15:0] speed;
    logic [15:0] x;
    logic [15:0] y;
  } drive_decision_t;

  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_REPORTS   = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dcl_rx_if  rx_ch();
  dcl_cmd_if cmd_ch();
  dcl_cfg_if cfg_ch();

  drive_command_line_parser_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (rx_ch),
    .out_bus(cmd_ch),
    .cfg_bus(cfg_ch)
  );

  always #4 clk = ~clk;

  logic [4:0]  ln_phase;
  int unsigned ln_mag;
  bit          ln_neg;
  bit          ln_seen;
  int          ln_x;
  int          ln_y;
  int          db_now;

  drive_decision_t pending_cmds[$];
  byte unsigned    line_buf[$];

  int bad_beats = 0;
  int bytes_sent = 0;
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int quiet_cycles = 0;

  string head_pat = "$RP,X,";
  string mid_pat = ",Y,";

  // line parser mirror

  function void clear_line();
    ln_phase = PH_LIT0;
    ln_mag = 0;
    ln_neg = 1'b0;
    ln_seen = 1'b0;
    ln_x = 0;
    ln_y = 0;
  endfunction

  function automatic int held_value();
    int unsigned m;
    m = ln_mag;
    if (ln_neg) begin
      if (m > 32768) m = 32768;
      return -int'(m);
    end
    if (m > 32767) m = 32767;
    return int'(m);
  endfunction

  function void commit_number();
    if (ln_phase == PH_XBODY) ln_x = held_value();
    else ln_y = held_value();
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function void feed_char(input logic [7:0] c);
    bit again;
    logic [4:0] p;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      p = ln_phase;
      if (p < PH_XPRE) begin
        ln_phase = (c == head_pat[p]) ? p + 5'd1 : PH_DONE;
      end else if (p == PH_XPRE || p == PH_YPRE) begin
        if (!is_blank(c)) begin
          ln_mag = 0;
          ln_neg = 1'b0;
          ln_seen = 1'b0;
          ln_phase = p + 5'd1;
          if (c == CH_PLUS || c == CH_MINUS) ln_neg = (c == CH_MINUS);
          else again = 1'b1;
        end
      end else if (p == PH_XBODY || p == PH_YBODY) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          ln_mag = ln_mag * 10 + (c - CH_ZERO);
          if (ln_mag > 32768) ln_mag = 32768;
          ln_seen = 1'b1;
        end else if (!ln_seen) begin
          ln_phase = PH_DONE;
        end else begin
          commit_number();
          ln_phase = p + 5'd1;
          again = 1'b1;
        end
      end else if (p >= PH_LIT1 && p < PH_YPRE) begin
        ln_phase = (c == mid_pat[p - PH_LIT1]) ? p + 5'd1 : PH_DONE;
      end else begin
        ln_phase = PH_DONE;
      end
    end
  endfunction

  function void parse_step(input logic [7:0] c);
    logic [2:0] cmd;
    int spd;
    if (c != CH_NL) begin
      if (c == CH_NUL) begin
        if (ln_phase == PH_XBODY || ln_phase == PH_YBODY) begin
          if (ln_seen) commit_number();
        end
        ln_phase = PH_DONE;
      end else begin
        feed_char(c);
      end
      return;
    end
    if ((ln_phase == PH_XBODY || ln_phase == PH_YBODY) && ln_seen) commit_number();
    cmd = CMD_NONE;
    spd = 0;
    if (ln_x == 0 && ln_y == 0) begin
      cmd = CMD_STOP;
    end else if (ln_x > -db_now && ln_x < db_now) begin
      if (ln_y > 0) begin
        cmd = CMD_FWD;
        spd = ln_y;
      end else if (ln_y < 0) begin
        cmd = CMD_BACK;
        spd = -ln_y;
      end
    end else if (ln_y > -db_now && ln_y < db_now) begin
      if (ln_x < 0) begin
        cmd = CMD_LEFT;
        spd = -ln_x;
      end else if (ln_x > 0) begin
        cmd = CMD_RIGHT;
        spd = ln_x;
      end
    end else begin
      cmd = CMD_STOP;
    end
    pending_cmds.push_back('{cmd, spd[15:0], ln_x[15:0], ln_y[15:0]});
    clear_line();
  endfunction

  // decision checker

  always @(posedge clk) begin : check_decisions
    drive_decision_t want;
    if (rst_n && cmd_ch.valid && cmd_ch.ready) begin
      if (pending_cmds.size() == 0) begin
        bad_beats++;
        if (bad_beats <= MAX_REPORTS)
          $display("unexpected decision: cmd %0d speed %0d x %0d y %0d",
                   cmd_ch.drive_command, cmd_ch.speed_hundredths,
                   cmd_ch.x_value, cmd_ch.y_value);
      end else begin
        want = pending_cmds.pop_front();
        if (want.cmd !== cmd_ch.drive_command || want.speed !== cmd_ch.speed_hundredths ||
            want.x !== cmd_ch.x_value || want.y !== cmd_ch.y_value) begin
          bad_beats++;
          if (bad_beats <= MAX_REPORTS)
            $display("mismatch: exp cmd %0d spd %0d x %0d y %0d, got cmd %0d spd %0d x %0d y %0d",
                     want.cmd, want.speed, $signed(want.x), $signed(want.y),
                     cmd_ch.drive_command, cmd_ch.speed_hundredths,
                     cmd_ch.x_value, cmd_ch.y_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((rx_ch.valid && rx_ch.ready) || (cmd_ch.valid && cmd_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** drive_command_line_parser_core: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    cmd_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // byte and register traffic

  task automatic send_char(input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= c;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    parse_step(c);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic settle();
    @(negedge clk);
    rx_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_deadband(input logic [14:0] v);
    settle();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.deadband <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    db_now = int'(v);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // random line builder

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 4))
      0:       return CH_TAB;
      1:       return CH_VT;
      2:       return CH_FF;
      3:       return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [14:0] pick_deadband();
    case ($urandom_range(0, 5))
      0:       return 15'd0;
      1:       return 15'h7FFF;
      2:       return 15'($urandom_range(0, 32767));
      default: return 15'($urandom_range(1, 400));
    endcase
  endfunction

  function void push_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function void push_number();
    int unsigned r;
    int unsigned mag;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) line_buf.push_back(pick_blank());
    case ($urandom_range(0, 2))
      1:       line_buf.push_back(CH_PLUS);
      2:       line_buf.push_back(CH_MINUS);
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) line_buf.push_back(CH_ZERO);
    r = $urandom_range(0, 9);
    if (r == 0) begin
      repeat ($urandom_range(5, 9)) line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end else begin
      case (r)
        1:          mag = 0;
        2, 3, 4, 5: mag = $urandom_range(0, db_now + 1);
        6:          mag = 32766 + $urandom_range(0, 3);
        default:    mag = $urandom_range(0, 32767);
      endcase
      push_text($sformatf("%0d", mag));
    end
  endfunction

  function void build_line();
    int unsigned pos;
    line_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
      line_buf.push_back(CH_NL);
      return;
    end
    push_text("$RP,X,");
    push_number();
    push_text(",Y,");
    push_number();
    if ($urandom_range(0, 3) != 0) push_text(";");
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 5)) line_buf.push_back(8'($urandom_range(32, 126)));
    if ($urandom_range(0, 4) == 0) begin
      pos = $urandom_range(0, line_buf.size() - 1);
      case ($urandom_range(0, 2))
        0:       line_buf[pos] = 8'($urandom_range(0, 255));
        1:       line_buf.delete(pos);
        default: line_buf.insert(pos, CH_NUL);
      endcase
    end
    line_buf.push_back(CH_NL);
  endfunction

  // tests

  task automatic test_command_kinds();
    send_text("$RP,X,0,Y,20;\n");
    send_text("$RP,X,3,Y,-32768;\n");
    send_text("$RP,X,-32768,Y,0;\n");
    send_text("$RP,X,");
    send_char(CH_SPACE);
    send_char(CH_TAB);
    send_text("+32767,Y,");
    send_char(CH_CR);
    send_char(CH_VT);
    send_char(CH_FF);
    send_text("-5;\n");
    send_text("$RP,X,40,Y,40;\n");
    send_text("$RP,X,7,Y,0;\n");
  endtask

  task automatic test_line_faults();
    send_text("$RP,X,0,Y,0;trailing\n");
    send_char(CH_NL);
    send_text("$RP,X,-,Y,5;\n");
    send_text("$RP,X,99999999,Y,-99999;\n");
    send_text("$RP,X,5,Y,12\n");
    send_text("$RP,X,-20");
    send_char(CH_NUL);
    send_text("abc,Y,3;\n");
    send_text("$RP,X,20,Y,x;\n");
    send_text("$rp,X,1,Y,1;\n");
    send_text("$RP,X,1;Y,1;\n");
    send_text("$RP,X,2");
    send_char(8'hFF);
    send_char(CH_NL);
  endtask

  task automatic test_deadband_extremes();
    write_deadband(15'd0);
    send_text("$RP,X,0,Y,9;\n");
    send_text("$RP,X,-1,Y,0;\n");
    write_deadband(15'h7FFF);
    send_text("$RP,X,-32768,Y,32767;\n");
    send_text("$RP,X,-32767,Y,-32767;\n");
    write_deadband(15'd1);
    send_text("$RP,X,0,Y,-1;\n");
  endtask

  task automatic test_random_lines(input int n_bytes, input int in_pct, input int out_pct);
    int stop_at;
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    write_deadband(pick_deadband());
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 39) == 0) begin
        if ($urandom_range(0, 1) == 1) write_deadband(pick_deadband());
        else settle();
      end
      build_line();
      foreach (line_buf[i]) send_char(line_buf[i]);
    end
  endtask

  initial begin
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.deadband = '0;
    cmd_ch.ready = 1'b0;
    clear_line();
    db_now = int'(DEADBAND_RST);
    in_idle_pct = 10;
    out_idle_pct = 83;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_command_kinds();
    test_line_faults();
    test_deadband_extremes();
    test_random_lines(400, 10, 83);
    test_random_lines(400, 83, 10);
    test_random_lines(400, 0, 0);

    settle();
    repeat (8) @(posedge clk);
    if (bad_beats == 0 && pending_cmds.size() == 0)
      $display("** drive_command_line_parser_core: PASSED **");
    else
      $display("** drive_command_line_parser_core: FAILED **");
    $finish;
  end

endmodule

// ----- drive_command_line_parser_core.f -----
hdl/dcl_pkg.sv
hdl/dcl_rx_if.sv
hdl/dcl_cmd_if.sv
hdl/dcl_cfg_if.sv
hdl/dcl_match.sv
hdl/drive_command_line_parser_core.sv
verif/tb.sv
